// File: hdl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_R = 2'd0,
    ACT_PUSH_L = 2'd1,
    ACT_POP_R  = 2'd2,
    ACT_POP_L  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // What one lane of every cell does in a cycle.
  typedef enum logic [1:0] {
    LANE_HOLD   = 2'd0,
    LANE_GROW   = 2'd1,
    LANE_SHRINK = 2'd2,
    LANE_APPEND = 2'd3
  } lane_op_t;

  typedef struct packed {
    lane_op_t op_l;
    lane_op_t op_r;
  } cell_ctrl_t;

  typedef struct packed {
    status_t status;
    logic    take_l;
    logic    take_r;
  } result_info_t;

endpackage

`default_nettype wire

// File: hdl/cdq_if.sv
`default_nettype none

interface cdq_in_if;
  import cdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic signed [VALUE_W-1:0] pop_value;
  logic [COUNT_W-1:0]  item_count;

  modport source (output valid, output status, output pop_value, output item_count,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input item_count,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/circular_deque.sv
// A result beat is registered and presented in the cycle after its input beat is accepted.
// Throughput: one item per cycle while the result is not stalled; every action shifts or
// loads each cell of a lane by at most a single neighbor step.
// An input beat is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) empties the deque and drops any pending result;
// the cell contents are not cleared, since an entry is only read after a push.
`default_nettype none

module circular_deque #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cdq_in_if.sink      in_ch,
  cdq_out_if.source   out_ch
);
  import cdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // The deque is kept twice, in two lanes that run through the same row of
  // cells. In the left lane, cell k holds the k-th entry counted from the left
  // end; in the right lane, cell k holds the k-th entry counted from the right
  // end. Both ends therefore always sit in cell 0 of some lane, and every
  // action becomes one of three moves per lane:
  //   grow   - every cell takes its lower neighbor, cell 0 takes the new value
  //   shrink - every cell takes its upper neighbor
  //   append - the first free cell (index equal to the count) takes the value
  // A push on one end grows that end's lane and appends to the other lane.
  // A pop reads cell 0 of its end's lane and shrinks that lane only; the
  // other lane keeps a stale copy past the new count, which is never read.

  logic                  accept;
  logic                  in_ready;
  cell_ctrl_t            cell_ctrl;
  result_info_t          info;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_after;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] pop_data;
  logic [DATA_WIDTH-1:0] lane_l [DEPTH];
  logic [DATA_WIDTH-1:0] lane_r [DEPTH];

  logic                      out_valid_r;
  status_t                   status_r;
  logic signed [VALUE_W-1:0] pop_value_r;
  logic [COUNT_W-1:0]        item_count_r;

  // The result register frees up in the same cycle that its beat is taken,
  // so a new beat can enter while the previous result leaves.
  assign in_ready    = rst_n && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // Only the low DATA_WIDTH bits of a pushed value are kept; when the cells
  // are wider than the port, the value is zero extended.
  assign push_data = DATA_WIDTH'($unsigned(in_ch.push_value));

  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .action      (action_t'(in_ch.action)),
    .cell_ctrl   (cell_ctrl),
    .info        (info),
    .count       (count),
    .count_after (count_after)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] lo_l, lo_r, hi_l, hi_r;

    if (k == 0) begin : g_first
      assign lo_l = push_data;
      assign lo_r = push_data;
    end else begin : g_inner_lo
      assign lo_l = lane_l[k-1];
      assign lo_r = lane_r[k-1];
    end

    // Past the last cell nothing is held; a shrink fills it with zero.
    if (k == DEPTH - 1) begin : g_last
      assign hi_l = '0;
      assign hi_r = '0;
    end else begin : g_inner_hi
      assign hi_l = lane_l[k+1];
      assign hi_r = lane_r[k+1];
    end

    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cell_ctrl (cell_ctrl),
      .tail_hit  (count == CW'(k)),
      .push_data (push_data),
      .lo_l      (lo_l),
      .hi_l      (hi_l),
      .lo_r      (lo_r),
      .hi_r      (hi_r),
      .data_l    (lane_l[k]),
      .data_r    (lane_r[k])
    );
  end

  // A successful pop reads the head cell of its lane before the shift lands.
  always_comb begin
    if (info.take_l) begin
      pop_data = lane_l[0];
    end else if (info.take_r) begin
      pop_data = lane_r[0];
    end else begin
      pop_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The popped value is sign extended from the cell width, or cut to the
  // port width when the cells are wider.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= info.status;
      pop_value_r  <= VALUE_W'($signed(pop_data));
      item_count_r <= COUNT_W'(count_after);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.pop_value  = pop_value_r;
  assign out_ch.item_count = item_count_r;

endmodule

`default_nettype wire

// File: hdl/cdq_cell.sv
`default_nettype none

module cdq_cell #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire cdq_pkg::cell_ctrl_t    cell_ctrl,
  input  wire logic                   tail_hit,
  input  wire logic [DATA_WIDTH-1:0]  push_data,
  input  wire logic [DATA_WIDTH-1:0]  lo_l,
  input  wire logic [DATA_WIDTH-1:0]  hi_l,
  input  wire logic [DATA_WIDTH-1:0]  lo_r,
  input  wire logic [DATA_WIDTH-1:0]  hi_r,
  output logic      [DATA_WIDTH-1:0]  data_l,
  output logic      [DATA_WIDTH-1:0]  data_r
);
  import cdq_pkg::*;

  logic [DATA_WIDTH-1:0] data_l_r, data_l_nxt;
  logic [DATA_WIDTH-1:0] data_r_r, data_r_nxt;

  // Each lane either keeps its entry, takes the neighbor nearer its anchor
  // (grow), takes the neighbor farther away (shrink), or loads the pushed
  // value when this cell is the first free one (append).
  always_comb begin
    data_l_nxt = data_l_r;
    case (cell_ctrl.op_l)
      LANE_GROW:   data_l_nxt = lo_l;
      LANE_SHRINK: data_l_nxt = hi_l;
      LANE_APPEND: if (tail_hit) begin
        data_l_nxt = push_data;
      end
      default:     data_l_nxt = data_l_r;
    endcase
  end

  always_comb begin
    data_r_nxt = data_r_r;
    case (cell_ctrl.op_r)
      LANE_GROW:   data_r_nxt = lo_r;
      LANE_SHRINK: data_r_nxt = hi_r;
      LANE_APPEND: if (tail_hit) begin
        data_r_nxt = push_data;
      end
      default:     data_r_nxt = data_r_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_l_r <= data_l_nxt;
    data_r_r <= data_r_nxt;
  end

  assign data_l = data_l_r;
  assign data_r = data_r_r;

endmodule

`default_nettype wire

// File: hdl/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire cdq_pkg::action_t      action,
  output cdq_pkg::cell_ctrl_t        cell_ctrl,
  output cdq_pkg::result_info_t      info,
  output logic [CW-1:0]              count,
  output logic [CW-1:0]              count_after
);
  import cdq_pkg::*;

  logic [CW-1:0] count_r, count_nxt;
  logic          full;
  logic          empty;
  cell_ctrl_t    ops;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    ops.op_l    = LANE_HOLD;
    ops.op_r    = LANE_HOLD;
    info.status = ST_OK;
    info.take_l = 1'b0;
    info.take_r = 1'b0;
    count_after = count_r;
    case (action)
      ACT_PUSH_R: if (full) begin
        info.status = ST_OVER;
      end else begin
        ops.op_l    = LANE_APPEND;
        ops.op_r    = LANE_GROW;
        count_after = count_r + CW'(1);
      end
      ACT_PUSH_L: if (full) begin
        info.status = ST_OVER;
      end else begin
        ops.op_l    = LANE_GROW;
        ops.op_r    = LANE_APPEND;
        count_after = count_r + CW'(1);
      end
      ACT_POP_R: if (empty) begin
        info.status = ST_UNDER;
      end else begin
        ops.op_r    = LANE_SHRINK;
        info.take_r = 1'b1;
        count_after = count_r - CW'(1);
      end
      ACT_POP_L: if (empty) begin
        info.status = ST_UNDER;
      end else begin
        ops.op_l    = LANE_SHRINK;
        info.take_l = 1'b1;
        count_after = count_r - CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (accept) begin
      cell_ctrl = ops;
      count_nxt = count_after;
    end else begin
      cell_ctrl.op_l = LANE_HOLD;
      cell_ctrl.op_r = LANE_HOLD;
      count_nxt      = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

// File: hdl/cdq_checker.sv
`default_nettype none

module cdq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [cdq_pkg::STATUS_W-1:0]  out_status,
  input wire logic [cdq_pkg::VALUE_W-1:0]   out_pop_value,
  input wire logic [cdq_pkg::COUNT_W-1:0]   out_item_count
);
  import cdq_pkg::*;

  // A stalled result beat stays put with its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_pop_value) && $stable(out_item_count))
    else $error("result beat dropped or changed while stalled");

  // Every accepted input beat shows up as a result beat in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // Reset leaves no pending result.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // An underflow only happens on an empty deque and pops nothing.
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNDER) |-> (out_item_count == '0) &&
      (out_pop_value == '0))
    else $error("underflow with entries held or a value popped");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_pop_value  (out_ch.pop_value),
  .out_item_count (out_ch.item_count)
);

`default_nettype wire
